### sv/i2c_ram_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_ram_pkg
// Shared codes and the transaction plan of the register access master.
// ----------------------------------------------------------------------------
package i2c_ram_pkg;

  localparam int CmdW      = 2;
  localparam int ByteW     = 8;
  localparam int WaitW     = 20;
  localparam int SegW      = 4;
  localparam int SInDataW  = 32;
  localparam int MOutDataW = 16;

  localparam logic [WaitW-1:0] WaitReset = 20'd10000;

  localparam logic [CmdW-1:0] CMD_TICK  = 2'd0;
  localparam logic [CmdW-1:0] CMD_WRITE = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd2;

  localparam logic [SegW-1:0] SEG_START   = 4'd0;
  localparam logic [SegW-1:0] SEG_ACK     = 4'd1;
  localparam logic [SegW-1:0] SEG_STOP    = 4'd2;
  localparam logic [SegW-1:0] SEG_RESTART = 4'd3;
  localparam logic [SegW-1:0] SEG_READ    = 4'd4;
  localparam logic [SegW-1:0] SEG_WR_ADDR = 4'd5;
  localparam logic [SegW-1:0] SEG_REG     = 4'd6;
  localparam logic [SegW-1:0] SEG_DATA    = 4'd7;
  localparam logic [SegW-1:0] SEG_RD_ADDR = 4'd8;

  localparam logic [SegW-1:0] WriteLastSeg = 4'd7;
  localparam logic [SegW-1:0] ReadLastSeg  = 4'd10;

  // segment kind at a position of the write or read plan
  function automatic logic [SegW-1:0] plan_kind(input logic rd, input logic [SegW-1:0] seg);
    logic [SegW-1:0] kind;
    kind = SEG_STOP;
    if (rd) begin
      case (seg)
        4'd0:    kind = SEG_START;
        4'd1:    kind = SEG_WR_ADDR;
        4'd2:    kind = SEG_ACK;
        4'd3:    kind = SEG_REG;
        4'd4:    kind = SEG_ACK;
        4'd5:    kind = SEG_RESTART;
        4'd6:    kind = SEG_RD_ADDR;
        4'd7:    kind = SEG_ACK;
        4'd8:    kind = SEG_READ;
        4'd9:    kind = SEG_ACK;
        default: kind = SEG_STOP;
      endcase
    end else begin
      case (seg)
        4'd0:    kind = SEG_START;
        4'd1:    kind = SEG_WR_ADDR;
        4'd2:    kind = SEG_ACK;
        4'd3:    kind = SEG_REG;
        4'd4:    kind = SEG_ACK;
        4'd5:    kind = SEG_DATA;
        4'd6:    kind = SEG_ACK;
        default: kind = SEG_STOP;
      endcase
    end
    return kind;
  endfunction

endpackage

### sv/i2c_register_access_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_master
// Tick driven I2C master for single register writes and random reads.
// ----------------------------------------------------------------------------
// Every item on the s_t* channel is one tick. A tick with tuser set to write
// or read starts a transaction if the master is idle; otherwise the command
// is ignored. Each busy tick outside the post-write wait does one line step
// (drive SCL or SDA, or sample SDA); acks are clocked with SDA released and
// never checked. A write takes 88 ticks plus the post-write wait from the cfg
// channel; a read takes 111 ticks. Idle ticks hold both line levels.
// Every accepted tick gives exactly one item on the m_t* channel, in the next
// cycle, from a single output register. A tick can be taken every cycle:
// s_tready is high while the output register is empty or being drained.
// If the receiver stalls, the result holds and s_tready drops until taken.
// Reset puts the master idle with both lines released, read_data at zero
// and the post-write wait at 10000 ticks. cfg_ready is always high; a write
// there applies to each write transaction that finishes its stop after it.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // device_address, register_address, write_data, sda_in, zero pad
  input  logic [i2c_ram_pkg::SInDataW-1:0]      s_tdata,
  // cmd
  input  logic [i2c_ram_pkg::CmdW-1:0]          s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // scl_out, sda_out, read_data, busy_res, done_res, zero pad
  output logic [i2c_ram_pkg::MOutDataW-1:0]     m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [i2c_ram_pkg::WaitW-1:0]         cfg_data
);
  import i2c_ram_pkg::*;

  logic [WaitW-1:0] write_wait_ticks;
  logic             busy, busy_next;
  logic             waiting, waiting_next;
  logic             is_read, is_read_next;
  logic [ByteW-1:0] held_device, held_device_next;
  logic [ByteW-1:0] held_register, held_register_next;
  logic [ByteW-1:0] held_data, held_data_next;
  logic [SegW-1:0]  seg, seg_next;
  logic [1:0]       sub, sub_next;
  logic [2:0]       bitn, bitn_next;
  logic [ByteW-1:0] shift_byte, shift_byte_next;
  logic [WaitW-1:0] wait_count, wait_count_next;
  logic             clock_level, clock_level_next;
  logic             data_level, data_level_next;
  logic [ByteW-1:0] received_byte, received_byte_next;
  logic             done;

  logic             accept;
  logic [CmdW-1:0]  cmd;
  logic             sda_in;
  logic             start;
  logic [SegW-1:0]  kind;
  logic [SegW-1:0]  cur_seg;
  logic [1:0]       cur_sub;
  logic [2:0]       cur_bit;
  logic [ByteW-1:0] tx_byte;
  logic             seg_end;
  logic             bit_end;
  logic [WaitW-1:0] wait_dec;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cmd       = s_tuser;
  assign sda_in    = s_tdata[24];
  assign start     = !busy && (cmd == CMD_WRITE || cmd == CMD_READ);
  assign wait_dec  = wait_count - WaitW'(1);

  always_comb begin
    is_read_next       = is_read;
    held_device_next   = held_device;
    held_register_next = held_register;
    held_data_next     = held_data;
    shift_byte_next    = shift_byte;
    if (start) begin
      is_read_next       = (cmd == CMD_READ);
      held_device_next   = s_tdata[7:0];
      held_register_next = s_tdata[15:8];
      held_data_next     = s_tdata[23:16];
      shift_byte_next    = '0;
    end
    cur_seg = start ? '0 : seg;
    cur_sub = start ? '0 : sub;
    cur_bit = start ? '0 : bitn;
    kind    = plan_kind(is_read_next, cur_seg);

    case (kind)
      SEG_WR_ADDR: tx_byte = held_device_next & 8'hFE;
      SEG_REG:     tx_byte = held_register_next;
      SEG_DATA:    tx_byte = held_data_next;
      default:     tx_byte = held_device_next | 8'h01;
    endcase

    busy_next          = busy;
    waiting_next       = waiting;
    seg_next           = seg;
    sub_next           = sub;
    bitn_next          = bitn;
    wait_count_next    = wait_count;
    clock_level_next   = clock_level;
    data_level_next    = data_level;
    received_byte_next = received_byte;
    done               = 1'b0;
    seg_end            = 1'b0;
    bit_end            = 1'b0;

    if (waiting) begin
      wait_count_next = wait_dec;
      if (wait_dec == '0) begin
        busy_next    = 1'b0;
        waiting_next = 1'b0;
        done         = 1'b1;
      end
    end else if (busy || start) begin
      busy_next = 1'b1;
      case (kind)
        SEG_START: begin
          if (cur_sub == 2'd0) data_level_next = 1'b1;
          else if (cur_sub == 2'd1) clock_level_next = 1'b1;
          else data_level_next = 1'b0;
          seg_end = (cur_sub == 2'd2);
        end
        SEG_ACK: begin
          if (cur_sub == 2'd0) clock_level_next = 1'b0;
          else if (cur_sub == 2'd1) data_level_next = 1'b1;
          else clock_level_next = 1'b1;
          seg_end = (cur_sub == 2'd2);
        end
        SEG_STOP: begin
          if (cur_sub == 2'd0) clock_level_next = 1'b0;
          else if (cur_sub == 2'd1) data_level_next = 1'b0;
          else if (cur_sub == 2'd2) clock_level_next = 1'b1;
          else data_level_next = 1'b1;
          seg_end = (cur_sub == 2'd3);
        end
        SEG_RESTART: begin
          if (cur_sub == 2'd0) clock_level_next = 1'b0;
          else if (cur_sub == 2'd1) data_level_next = 1'b1;
          else if (cur_sub == 2'd2) clock_level_next = 1'b1;
          else data_level_next = 1'b0;
          seg_end = (cur_sub == 2'd3);
        end
        SEG_READ: begin
          if (cur_sub == 2'd0) begin
            clock_level_next = 1'b0;
          end else begin
            clock_level_next = 1'b1;
            shift_byte_next  = {shift_byte_next[ByteW-2:0], sda_in};
          end
          bit_end = (cur_sub == 2'd1);
          seg_end = bit_end && (cur_bit == 3'd7);
        end
        default: begin
          if (cur_sub == 2'd0) clock_level_next = 1'b0;
          else if (cur_sub == 2'd1) data_level_next = tx_byte[~cur_bit];
          else clock_level_next = 1'b1;
          bit_end = (cur_sub == 2'd2);
          seg_end = bit_end && (cur_bit == 3'd7);
        end
      endcase

      if (seg_end) begin
        seg_next  = cur_seg + SegW'(1);
        sub_next  = '0;
        bitn_next = '0;
      end else if (bit_end) begin
        seg_next  = cur_seg;
        sub_next  = '0;
        bitn_next = cur_bit + 3'd1;
      end else begin
        seg_next  = cur_seg;
        sub_next  = cur_sub + 2'd1;
        bitn_next = cur_bit;
      end

      if (seg_end && cur_seg == (is_read_next ? ReadLastSeg : WriteLastSeg)) begin
        if (is_read_next) begin
          received_byte_next = shift_byte_next;
          busy_next          = 1'b0;
          done               = 1'b1;
        end else begin
          wait_count_next = write_wait_ticks;
          if (write_wait_ticks == '0) begin
            busy_next = 1'b0;
            done      = 1'b1;
          end else begin
            waiting_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_wait_ticks <= WaitReset;
    end else if (cfg_valid && cfg_ready) begin
      write_wait_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      waiting       <= 1'b0;
      clock_level   <= 1'b1;
      data_level    <= 1'b1;
      received_byte <= '0;
      seg           <= '0;
      sub           <= '0;
      bitn          <= '0;
    end else if (accept) begin
      busy          <= busy_next;
      waiting       <= waiting_next;
      clock_level   <= clock_level_next;
      data_level    <= data_level_next;
      received_byte <= received_byte_next;
      seg           <= seg_next;
      sub           <= sub_next;
      bitn          <= bitn_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_read       <= is_read_next;
      held_device   <= held_device_next;
      held_register <= held_register_next;
      held_data     <= held_data_next;
      shift_byte    <= shift_byte_next;
      wait_count    <= wait_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {4'b0000, done, busy_next, received_byte_next,
                  data_level_next, clock_level_next};
    end
  end

endmodule

### sv/i2c_ram_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_ram_checker
// Port level checks of the register access master, bound into that module.
// ----------------------------------------------------------------------------
module i2c_ram_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tvalid,
  input logic                                  s_tready,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [i2c_ram_pkg::MOutDataW-1:0]     m_tdata,
  input logic                                  cfg_ready
);
  import i2c_ram_pkg::*;

  // no item shown right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output item valid after reset");

  // stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output item changed");

  // a finishing tick never reports busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[10] && m_tdata[11]))
    else $error("done and busy together");

  // each accepted tick leaves one output item
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item gave no result");

  // input side is open whenever the output register can drain
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready && cfg_ready)
    else $error("ready low with output free");

endmodule

bind i2c_register_access_master i2c_ram_checker u_i2c_ram_checker (.*);
